// ----- rtl/cges_pkg.sv -----
// ============================================================================
// cges_pkg
// Shared widths, formats, cell payloads and saturation for the central
// gravity Euler step pipeline.
// ============================================================================
package cges_pkg;

    localparam int FRAC_BITS = 32;
    localparam int Q_W       = 48;              // signed Q16.32 word
    localparam int GM_W      = 48;              // unsigned Q0.48 gm
    localparam int TS_W      = 32;              // unsigned Q0.32 time step
    localparam int ADX_W     = Q_W;             // |body - center| fits 48 bits
    localparam int DEN_W     = 2 * ADX_W + 1;   // squared distance
    localparam int GM_SHIFT  = 3 * FRAC_BITS - GM_W;
    localparam int NA_W      = GM_W + GM_SHIFT; // gm numerator width
    localparam int QA_W      = 52;              // acceleration quotient bits
    localparam int A_W       = Q_W - 1;         // saturated acceleration
    localparam int ROOT_W    = ADX_W + 1;       // floor(sqrt(d2))
    localparam int RAD_W     = 2 * ROOT_W;      // radicand, padded to pairs
    localparam int SREM_W    = ROOT_W + 3;      // sqrt remainder
    localparam int MUL_W     = 64;
    localparam int MUL_LAT   = 2;
    localparam int DATA_W    = 4 * Q_W;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 5;

    localparam logic [127:0] CLOSE_LIM =
        ((128'd1 << (2 * FRAC_BITS)) + 128'd999999) / 128'd1000000;
    localparam logic [63:0]  NEAR_LIM  = ((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000;
    localparam logic [TS_W-1:0] TS_RESET = 32'd42949673;

    typedef enum logic [1:0] {
        REG_GM = 2'd0,
        REG_CX = 2'd1,
        REG_CY = 2'd2,
        REG_TS = 2'd3
    } reg_idx_t;

    // last field (px) in the lowest bits
    typedef struct packed {
        logic signed [Q_W-1:0] vy;
        logic signed [Q_W-1:0] vx;
        logic signed [Q_W-1:0] py;
        logic signed [Q_W-1:0] px;
    } body_t;

    typedef struct packed {
        logic [ADX_W-1:0] adx;
        logic [ADX_W-1:0] ady;
    } geo_t;

    typedef struct packed {
        logic near;
        logic dxn;
        logic dyn;
        logic dyp;
    } flg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] vy;
        logic signed [Q_W-1:0] vx;
    } vel_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QA_W-1:0]  num;
        logic [QA_W-1:0]  quo;
    } div_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
            r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/central_gravity_euler_step_top.sv -----
// ============================================================================
// central_gravity_euler_step_top
// One semi-implicit Euler step of a body around a fixed central mass.
// ============================================================================
// Throughput: one beat per cycle while the output drains; the cell chains of
//   the gm/d2 divider, the square root and the two component dividers each
//   finish one item per cycle, so the rate is set by the single-issue pipeline.
// Reset: rst_n clears all valid bits, including the output valid, and loads
//   the registers with gm = 0, center = (0,0), time_step = 0.01.
module central_gravity_euler_step_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cges_pkg::APB_AW-1:0]    paddr,
    input  logic [cges_pkg::APB_DW-1:0]    pwdata,
    output logic [cges_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // body in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cges_pkg::DATA_W-1:0]    s_tdata,  // pos_x, pos_y, vel_x, vel_y
    // body out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cges_pkg::DATA_W-1:0]    m_tdata,  // new_pos_x, new_pos_y,
                                                     // new_vel_x, new_vel_y
    output logic [0:0]                     m_tuser   // too_close
);
    import cges_pkg::*;

    // Stage numbers: the register of stage N is written from stage N-1.
    localparam int S_D2  = 5;                  // squared distance, close flag
    localparam int S_SQ  = S_D2 + ROOT_W;      // sqrt chain done
    localparam int S_QA  = S_D2 + QA_W;        // gm/d2 chain done
    localparam int S_A   = S_QA + 1;           // saturated acceleration
    localparam int S_PA  = S_A + MUL_LAT;      // a*|dx|, a*|dy|
    localparam int S_QM  = S_PA + A_W;         // component chains done
    localparam int S_MAG = S_QM + 1;           // component magnitude and sign
    localparam int S_PT  = S_MAG + MUL_LAT;    // component * dt
    localparam int S_NV  = S_PT + 1;           // new velocity
    localparam int S_NM  = S_NV + 1;           // |new velocity|
    localparam int S_PN  = S_NM + MUL_LAT;     // |new velocity| * dt
    localparam int S_NP  = S_PN + 1;           // new position, last stage

    localparam logic signed [Q_W:0] NEAR_S = (Q_W+1)'(NEAR_LIM);

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [GM_W-1:0] gm_reg;
    logic [Q_W-1:0]  cx_reg, cy_reg;
    logic [TS_W-1:0] ts_reg;
    reg_idx_t        cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            ts_reg <= TS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_GM:  gm_reg <= pwdata[GM_W-1:0];
                REG_CX:  cx_reg <= pwdata[Q_W-1:0];
                REG_CY:  cy_reg <= pwdata[Q_W-1:0];
                REG_TS:  ts_reg <= pwdata[TS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GM:  prdata = APB_DW'(gm_reg);
            REG_CX:  prdata = APB_DW'(cx_reg);
            REG_CY:  prdata = APB_DW'(cy_reg);
            REG_TS:  prdata = APB_DW'(ts_reg);
            default: prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Flow control: the whole pipe moves as one; it also moves while the
    // output register holds a beat, as long as the last stage is a bubble.
    //------------------------------------------------------------------
    logic  adv;
    logic  out_take;
    logic  vld_reg [1:S_NP];
    logic  out_vld_reg;
    body_t out_reg;
    logic  out_close_reg;

    assign out_take = !out_vld_reg || m_tready;
    assign adv      = !vld_reg[S_NP] || out_take;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= S_NP; i++)
                vld_reg[i] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg[1] <= s_tvalid;
                for (int i = 2; i <= S_NP; i++)
                    vld_reg[i] <= vld_reg[i-1];
            end
            if (out_take)
                out_vld_reg <= vld_reg[S_NP];
        end
    end

    //------------------------------------------------------------------
    // Payload pipeline
    //------------------------------------------------------------------
    body_t                  pv_reg    [1:S_PN];    // body beat, carried along
    geo_t                   geo_reg   [2:S_A];     // |dx|, |dy|
    flg_t                   flg_reg   [2:S_QM];    // axis and sign flags
    logic                   close_reg [S_D2:S_NP];
    logic [ROOT_W-1:0]      dist_reg  [S_SQ+1:S_PA];
    logic [A_W-1:0]         a_reg     [S_A:S_QM];
    logic [1:0]             sgn_reg   [S_MAG:S_PT]; // {neg y, neg x}
    vel_t                   nv_reg    [S_NV:S_PN];

    logic signed [Q_W:0]    dx1_reg, dy1_reg;
    logic [DEN_W-1:0]       d2_reg;
    logic [A_W-1:0]         magx_reg, magy_reg;
    logic [Q_W-1:0]         nvmx_reg, nvmy_reg;
    body_t                  res_reg;

    body_t                  in_body;
    logic [2*MUL_W-1:0]     sqx, sqy, pax, pay, ptx, pty, pnx, pny;
    logic [DEN_W:0]         d2_sum;
    div_t                   da  [0:QA_W];
    sq_t                    sqc [0:ROOT_W];
    div_t                   dmx [0:A_W];
    div_t                   dmy [0:A_W];
    logic [QA_W-1:0]        qa;
    logic [A_W-1:0]         a_next;
    flg_t                   fq;
    logic [A_W-1:0]         sx, sy;
    logic signed [Q_W:0]    nvx_w, nvy_w;
    vel_t                   nvq;
    logic [Q_W-1:0]         s2x, s2y;
    logic signed [Q_W:0]    npx_w, npy_w;
    logic [NA_W-1:0]        num_a;

    assign in_body = body_t'(s_tdata);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // offsets from the central body
            pv_reg[1] <= in_body;
            dx1_reg   <= {in_body.px[Q_W-1], in_body.px} - {cx_reg[Q_W-1], cx_reg};
            dy1_reg   <= {in_body.py[Q_W-1], in_body.py} - {cy_reg[Q_W-1], cy_reg};
            for (int i = 2; i <= S_PN; i++)
                pv_reg[i] <= pv_reg[i-1];

            // magnitudes and flags
            geo_reg[2].adx <= dx1_reg[Q_W] ? ADX_W'(-dx1_reg) : dx1_reg[ADX_W-1:0];
            geo_reg[2].ady <= dy1_reg[Q_W] ? ADX_W'(-dy1_reg) : dy1_reg[ADX_W-1:0];
            flg_reg[2].near <= (dx1_reg < NEAR_S) && (dx1_reg > -NEAR_S);
            flg_reg[2].dxn  <= dx1_reg[Q_W];
            flg_reg[2].dyn  <= dy1_reg[Q_W];
            flg_reg[2].dyp  <= !dy1_reg[Q_W] && (dy1_reg != '0);
            for (int i = 3; i <= S_A; i++)
                geo_reg[i] <= geo_reg[i-1];
            for (int i = 3; i <= S_QM; i++)
                flg_reg[i] <= flg_reg[i-1];

            // squared distance and the too-close test
            d2_reg          <= d2_sum[DEN_W-1:0];
            close_reg[S_D2] <= 128'(d2_sum) < CLOSE_LIM;
            for (int i = S_D2 + 1; i <= S_NP; i++)
                close_reg[i] <= close_reg[i-1];

            // hold the root until the component dividers start
            dist_reg[S_SQ+1] <= sqc[ROOT_W].root;
            for (int i = S_SQ + 2; i <= S_PA; i++)
                dist_reg[i] <= dist_reg[i-1];

            a_reg[S_A] <= a_next;
            for (int i = S_A + 1; i <= S_QM; i++)
                a_reg[i] <= a_reg[i-1];

            // component magnitude and sign; near the y axis all goes to y
            magx_reg       <= fq.near ? '0 : dmx[A_W].quo[A_W-1:0];
            magy_reg       <= fq.near ? a_reg[S_QM] : dmy[A_W].quo[A_W-1:0];
            sgn_reg[S_MAG] <= {fq.near ? !fq.dyp : fq.dyn, !fq.near && fq.dxn};
            for (int i = S_MAG + 1; i <= S_PT; i++)
                sgn_reg[i] <= sgn_reg[i-1];

            // new velocity, then its magnitude for the position step
            nv_reg[S_NV] <= nvq;
            for (int i = S_NV + 1; i <= S_PN; i++)
                nv_reg[i] <= nv_reg[i-1];
            nvmx_reg <= nv_reg[S_NV].vx[Q_W-1] ? Q_W'(-nv_reg[S_NV].vx) : nv_reg[S_NV].vx;
            nvmy_reg <= nv_reg[S_NV].vy[Q_W-1] ? Q_W'(-nv_reg[S_NV].vy) : nv_reg[S_NV].vy;

            res_reg.px <= sat_q(npx_w);
            res_reg.py <= sat_q(npy_w);
            res_reg.vx <= nv_reg[S_PN].vx;
            res_reg.vy <= nv_reg[S_PN].vy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_reg       <= res_reg;
            out_close_reg <= close_reg[S_NP];
        end
    end

    //------------------------------------------------------------------
    // Squares of the offsets
    //------------------------------------------------------------------
    cges_mul u_sqx (.clk(clk), .en(adv), .a(MUL_W'(geo_reg[2].adx)),
                    .b(MUL_W'(geo_reg[2].adx)), .p(sqx));
    cges_mul u_sqy (.clk(clk), .en(adv), .a(MUL_W'(geo_reg[2].ady)),
                    .b(MUL_W'(geo_reg[2].ady)), .p(sqy));

    assign d2_sum = {1'b0, sqx[DEN_W-1:0]} + {1'b0, sqy[DEN_W-1:0]};

    //------------------------------------------------------------------
    // a = gm * 2^GM_SHIFT / d2, one quotient bit per cell
    //------------------------------------------------------------------
    assign num_a   = NA_W'(gm_reg) << GM_SHIFT;
    assign da[0].rem = DEN_W'(num_a >> QA_W);
    assign da[0].den = d2_reg;
    assign da[0].num = num_a[QA_W-1:0];
    assign da[0].quo = '0;

    for (genvar k = 0; k < QA_W; k++)
    begin : g_diva
        cges_div_cell u_cell (.clk(clk), .en(adv), .d_in(da[k]), .d_out(da[k+1]));
    end

    // saturate; too close means no pull at all
    assign qa     = da[QA_W].quo;
    assign a_next = close_reg[S_QA] ? '0
                  : (|qa[QA_W-1:A_W]) ? {A_W{1'b1}} : qa[A_W-1:0];

    //------------------------------------------------------------------
    // dist = floor(sqrt(d2)), one root bit per cell
    //------------------------------------------------------------------
    assign sqc[0].rad  = RAD_W'(d2_reg);
    assign sqc[0].rem  = '0;
    assign sqc[0].root = '0;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        cges_sqrt_cell u_cell (.clk(clk), .en(adv), .s_in(sqc[k]), .s_out(sqc[k+1]));
    end

    //------------------------------------------------------------------
    // Components a*|d|/dist
    //------------------------------------------------------------------
    cges_mul u_pax (.clk(clk), .en(adv), .a(MUL_W'(a_reg[S_A])),
                    .b(MUL_W'(geo_reg[S_A].adx)), .p(pax));
    cges_mul u_pay (.clk(clk), .en(adv), .a(MUL_W'(a_reg[S_A])),
                    .b(MUL_W'(geo_reg[S_A].ady)), .p(pay));

    assign dmx[0].rem = DEN_W'(pax[A_W+ADX_W-1:A_W]);
    assign dmx[0].den = DEN_W'(dist_reg[S_PA]);
    assign dmx[0].num = {pax[A_W-1:0], {(QA_W-A_W){1'b0}}};
    assign dmx[0].quo = '0;
    assign dmy[0].rem = DEN_W'(pay[A_W+ADX_W-1:A_W]);
    assign dmy[0].den = DEN_W'(dist_reg[S_PA]);
    assign dmy[0].num = {pay[A_W-1:0], {(QA_W-A_W){1'b0}}};
    assign dmy[0].quo = '0;

    for (genvar k = 0; k < A_W; k++)
    begin : g_divm
        cges_div_cell u_cx (.clk(clk), .en(adv), .d_in(dmx[k]), .d_out(dmx[k+1]));
        cges_div_cell u_cy (.clk(clk), .en(adv), .d_in(dmy[k]), .d_out(dmy[k+1]));
    end

    assign fq = flg_reg[S_QM];

    //------------------------------------------------------------------
    // Velocity step: v - component*dt, truncated toward zero
    //------------------------------------------------------------------
    cges_mul u_ptx (.clk(clk), .en(adv), .a(MUL_W'(magx_reg)), .b(MUL_W'(ts_reg)), .p(ptx));
    cges_mul u_pty (.clk(clk), .en(adv), .a(MUL_W'(magy_reg)), .b(MUL_W'(ts_reg)), .p(pty));

    assign sx = ptx[A_W+TS_W-1:TS_W];
    assign sy = pty[A_W+TS_W-1:TS_W];

    always_comb
    begin
        nvx_w = sgn_reg[S_PT][0]
              ? {pv_reg[S_PT].vx[Q_W-1], pv_reg[S_PT].vx} + {2'b00, sx}
              : {pv_reg[S_PT].vx[Q_W-1], pv_reg[S_PT].vx} - {2'b00, sx};
        nvy_w = sgn_reg[S_PT][1]
              ? {pv_reg[S_PT].vy[Q_W-1], pv_reg[S_PT].vy} + {2'b00, sy}
              : {pv_reg[S_PT].vy[Q_W-1], pv_reg[S_PT].vy} - {2'b00, sy};
        nvq.vx = sat_q(nvx_w);
        nvq.vy = sat_q(nvy_w);
    end

    //------------------------------------------------------------------
    // Position step with the new velocity
    //------------------------------------------------------------------
    cges_mul u_pnx (.clk(clk), .en(adv), .a(MUL_W'(nvmx_reg)), .b(MUL_W'(ts_reg)), .p(pnx));
    cges_mul u_pny (.clk(clk), .en(adv), .a(MUL_W'(nvmy_reg)), .b(MUL_W'(ts_reg)), .p(pny));

    assign s2x = pnx[Q_W+TS_W-1:TS_W];
    assign s2y = pny[Q_W+TS_W-1:TS_W];

    always_comb
    begin
        npx_w = nv_reg[S_PN].vx[Q_W-1]
              ? {pv_reg[S_PN].px[Q_W-1], pv_reg[S_PN].px} - {1'b0, s2x}
              : {pv_reg[S_PN].px[Q_W-1], pv_reg[S_PN].px} + {1'b0, s2x};
        npy_w = nv_reg[S_PN].vy[Q_W-1]
              ? {pv_reg[S_PN].py[Q_W-1], pv_reg[S_PN].py} - {1'b0, s2y}
              : {pv_reg[S_PN].py[Q_W-1], pv_reg[S_PN].py} + {1'b0, s2y};
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_reg;
    assign m_tuser[0] = out_close_reg;

endmodule

// ----- rtl/cges_mul.sv -----
// ============================================================================
// cges_mul
// Unsigned 64x64 multiplier, four 32x32 partial products, two stages.
// ============================================================================
module cges_mul (
    input  logic                            clk,
    input  logic                            en,
    input  logic [cges_pkg::MUL_W-1:0]      a,
    input  logic [cges_pkg::MUL_W-1:0]      b,
    output logic [2*cges_pkg::MUL_W-1:0]    p
);
    import cges_pkg::*;

    localparam int H = MUL_W / 2;

    logic [MUL_W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[H-1:0] * b[H-1:0];
            lh_reg <= a[H-1:0] * b[MUL_W-1:H];
            hl_reg <= a[MUL_W-1:H] * b[H-1:0];
            hh_reg <= a[MUL_W-1:H] * b[MUL_W-1:H];
            p_reg  <= {hh_reg, ll_reg}
                    + {{H{1'b0}}, lh_reg, {H{1'b0}}}
                    + {{H{1'b0}}, hl_reg, {H{1'b0}}};
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/cges_div_cell.sv -----
// ============================================================================
// cges_div_cell
// One restoring division step: shift in a numerator bit, subtract if it fits.
// ============================================================================
module cges_div_cell (
    input  logic            clk,
    input  logic            en,
    input  cges_pkg::div_t  d_in,
    output cges_pkg::div_t  d_out
);
    import cges_pkg::*;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    div_t           q_reg;

    always_comb
    begin
        trial = {d_in.rem, d_in.num[QA_W-1]};
        diff  = trial - {1'b0, d_in.den};
        ge    = trial >= {1'b0, d_in.den};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg.rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg.den <= d_in.den;
            q_reg.num <= {d_in.num[QA_W-2:0], 1'b0};
            q_reg.quo <= {d_in.quo[QA_W-2:0], ge};
        end
    end

    assign d_out = q_reg;

endmodule

// ----- rtl/cges_sqrt_cell.sv -----
// ============================================================================
// cges_sqrt_cell
// One digit-by-digit square root step: bring down two radicand bits.
// ============================================================================
module cges_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  cges_pkg::sq_t  s_in,
    output cges_pkg::sq_t  s_out
);
    import cges_pkg::*;

    logic [SREM_W-1:0] t;
    logic [SREM_W-1:0] trial;
    logic              ge;
    sq_t               q_reg;

    always_comb
    begin
        t     = {s_in.rem[SREM_W-3:0], s_in.rad[RAD_W-1:RAD_W-2]};
        trial = SREM_W'({s_in.root, 2'b01});
        ge    = t >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg.rad  <= {s_in.rad[RAD_W-3:0], 2'b00};
            q_reg.rem  <= ge ? (t - trial) : t;
            q_reg.root <= {s_in.root[ROOT_W-2:0], ge};
        end
    end

    assign s_out = q_reg;

endmodule

// ----- rtl/cges_checker.sv -----
// ============================================================================
// cges_checker
// Port-level checks of the central gravity Euler step block.
// ============================================================================
module cges_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [cges_pkg::APB_AW-1:0]    paddr,
    input logic [cges_pkg::APB_DW-1:0]    pwdata,
    input logic [cges_pkg::APB_DW-1:0]    prdata,
    input logic                           pready,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cges_pkg::DATA_W-1:0]    s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cges_pkg::DATA_W-1:0]    m_tdata,
    input logic [0:0]                     m_tuser
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed under stall");

    // input side never blocks when the output side can drain
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with a free output");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    // gm write reads back
    a_gm_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[4:3] == cges_pkg::REG_GM)
        |=> (paddr[4:3] != cges_pkg::REG_GM || prdata[47:0] == $past(pwdata[47:0])))
        else $error("gm readback mismatch");

endmodule

bind central_gravity_euler_step_top cges_checker u_cges_checker (.*);

// ----- sim/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the central gravity Euler step pipeline.
// ============================================================================
// Each accepted body beat is predicted bit for bit and queued. The checker
// compares every output beat with the oldest prediction. Both sides stall at
// random, except during one long steady stretch. Register writes go over the
// APB port only while the pipeline is drained.
module tb;
    import cges_pkg::*;

    localparam logic signed [63:0] QMAX = 64'sd140737488355327;
    localparam logic signed [63:0] QMIN = -64'sd140737488355328;
    localparam int DRAIN_CYCLES = 200;   // well past the pipeline latency

    typedef struct {
        logic [Q_W-1:0] npx;
        logic [Q_W-1:0] npy;
        logic [Q_W-1:0] nvx;
        logic [Q_W-1:0] nvy;
        logic           close;
    } motion_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // pos_x, pos_y, vel_x, vel_y
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    logic [0:0]        m_tuser;   // too_close

    // shadow copy of the register file
    logic [GM_W-1:0] gm_q;
    logic [Q_W-1:0]  cx_q;
    logic [Q_W-1:0]  cy_q;
    logic [TS_W-1:0] ts_q;

    motion_t pending_motion[$];
    int      errors;
    bit      steady;

    central_gravity_euler_step_top uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous wall: the run itself needs far fewer cycles.
    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // Receiver side: drop ready about 16 times in a hundred.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 16);

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v;
    endfunction

    // v * time_step >> 32, truncated toward zero
    function automatic logic signed [63:0] times_dt(input logic signed [63:0] v);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  s;
        mag  = v < 0 ? -v : v;
        prod = {64'd0, mag} * {96'd0, ts_q};
        s    = prod[95:32];
        return v < 0 ? -$signed(s) : $signed(s);
    endfunction

    function automatic motion_t step_body(input body_t b);
        logic signed [63:0] px, py, vx, vy, dx, dy, ax, ay, nvx, nvy, npx, npy, a;
        logic [127:0] adx, ady, d2, quo, root, cand, mx, my;
        motion_t m;
        px  = 64'(b.px);
        py  = 64'(b.py);
        vx  = 64'(b.vx);
        vy  = 64'(b.vy);
        dx  = px - 64'($signed(cx_q));
        dy  = py - 64'($signed(cy_q));
        adx = dx < 0 ? 128'(-dx) : 128'(dx);
        ady = dy < 0 ? 128'(-dy) : 128'(dy);
        d2  = adx * adx + ady * ady;
        m.close = (d2 * 128'd1000000) < (128'd1 << (2 * FRAC_BITS));
        a = '0;
        if (!m.close)
        begin
            quo = ({80'd0, gm_q} << GM_SHIFT) / d2;
            a   = quo > 128'(QMAX) ? QMAX : $signed(quo[63:0]);
        end
        if (adx * 128'd1000 < (128'd1 << FRAC_BITS))
        begin
            // near the y axis: all of the pull goes along y
            ax = '0;
            ay = dy > 0 ? a : -a;
        end
        else
        begin
            root = '0;
            for (int k = 48; k >= 0; k--)
            begin
                cand = root | (128'd1 << k);
                if (cand * cand <= d2)
                    root = cand;
            end
            mx = (128'(a) * adx) / root;
            my = (128'(a) * ady) / root;
            ax = dx < 0 ? -$signed(mx[63:0]) : $signed(mx[63:0]);
            ay = dy < 0 ? -$signed(my[63:0]) : $signed(my[63:0]);
        end
        nvx = sat_word(vx - times_dt(ax));
        nvy = sat_word(vy - times_dt(ay));
        npx = sat_word(px + times_dt(nvx));
        npy = sat_word(py + times_dt(nvy));
        m.npx = npx[Q_W-1:0];
        m.npy = npy[Q_W-1:0];
        m.nvx = nvx[Q_W-1:0];
        m.nvy = nvy[Q_W-1:0];
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        motion_t want;
        body_t   got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_motion.size() == 0)
            begin
                $error("output beat with no prediction pending");
                errors++;
            end
            else
            begin
                want = pending_motion.pop_front();
                if (got.px !== want.npx)
                begin
                    $error("new_pos_x expected %h got %h", want.npx, got.px);
                    errors++;
                end
                if (got.py !== want.npy)
                begin
                    $error("new_pos_y expected %h got %h", want.npy, got.py);
                    errors++;
                end
                if (got.vx !== want.nvx)
                begin
                    $error("new_vel_x expected %h got %h", want.nvx, got.vx);
                    errors++;
                end
                if (got.vy !== want.nvy)
                begin
                    $error("new_vel_y expected %h got %h", want.nvy, got.vy);
                    errors++;
                end
                if (m_tuser[0] !== want.close)
                begin
                    $error("too_close expected %b got %b", want.close, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Send one body beat; hold valid high afterwards so back-to-back beats
    // stream without a bubble unless a gap is drawn.
    task automatic send_body(input logic [Q_W-1:0] px, input logic [Q_W-1:0] py,
                             input logic [Q_W-1:0] vx, input logic [Q_W-1:0] vy);
        body_t b;
        b.px = px;
        b.py = py;
        b.vx = vx;
        b.vy = vy;
        if (!steady && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        pending_motion = {pending_motion, step_body(b)};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_motion.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GM:  gm_q = value[GM_W-1:0];
            REG_CX:  cx_q = value[Q_W-1:0];
            REG_CY:  cy_q = value[Q_W-1:0];
            REG_TS:  ts_q = value[TS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [Q_W-1:0] any_word();
        return Q_W'({$urandom, $urandom});
    endfunction

    // random word at a random magnitude, so every scale gets exercised
    function automatic logic [Q_W-1:0] scaled_word();
        logic signed [Q_W-1:0] w;
        w = any_word();
        return w >>> $urandom_range(0, 47);
    endfunction

    function automatic logic [Q_W-1:0] near_center(input logic [Q_W-1:0] c);
        return c + scaled_word();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // gm is zero after reset: bodies coast at the default step
        send_body(48'd1 << 32, 48'd0, 48'd1 << 32, -(48'd1 << 31));
        send_body(any_word(), any_word(), any_word(), any_word());
    endtask

    task automatic test_extremes();
        write_reg(REG_GM, 64'h0000_1234_5678_9ABC);
        send_body(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                  48'h7FFF_FFFF_FFFF);
        send_body(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                  48'h8000_0000_0000);
        send_body(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
                  48'h7FFF_FFFF_FFFF);
        send_body(48'd0, 48'd0, 48'd0, 48'd0);
    endtask

    task automatic test_close_bodies();
        send_body(48'd0, 48'd0, 48'd5 << 32, -(48'd3 << 32));
        send_body(48'd100, -(48'd200), 48'd7, 48'd9);
        send_body(48'd4294, 48'd0, 48'd1 << 30, 48'd0);   // well inside the close radius
    endtask

    task automatic test_near_axis();
        send_body(48'd0, 48'd1 << 32, 48'd1 << 32, 48'd0);      // dy > 0
        send_body(48'd1000, -(48'd2 << 32), 48'd0, 48'd1 << 32); // dy < 0
        send_body(-(48'd4000), 48'd0, 48'd0, 48'd0);            // dy == 0
        send_body(48'd4295, 48'd3 << 32, 48'd0, 48'd0);          // still inside the near-axis band
    endtask

    task automatic test_saturation();
        write_reg(REG_GM, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_TS, 64'hFFFF_FFFF);
        // bodies well inside the close radius: no pull even at the largest gm
        send_body(48'd4400, 48'd0, 48'd0, 48'd0);
        send_body(-(48'd5000), 48'd5000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        // position pushed past the top by the velocity
        send_body(48'h7FFF_0000_0000, 48'd0, 48'h7FFF_FFFF_FFFF, 48'd0);
        send_body(48'h8000_1000_0000, 48'h8000_1000_0000, 48'h8000_0000_0000,
                  48'h8000_0000_0000);
        write_reg(REG_TS, 64'd0);
        send_body(any_word(), any_word(), any_word(), any_word());
    endtask

    // Random bodies under one register setting: mostly orbits around the
    // center at every scale, some fully random noise.
    task automatic test_random_phase(input logic [63:0] gm, input logic [63:0] cx,
                                     input logic [63:0] cy, input logic [63:0] ts,
                                     input int count);
        write_reg(REG_GM, gm);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_TS, ts);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 80)
                send_body(near_center(cx_q), near_center(cy_q), scaled_word(),
                          scaled_word());
            else
                send_body(any_word(), any_word(), any_word(), any_word());
        end
    endtask

    initial
    begin
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
        errors   = 0;
        gm_q     = '0;
        cx_q     = '0;
        cy_q     = '0;
        ts_q     = TS_RESET;
        rst_n    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_close_bodies();
        test_near_axis();
        test_saturation();

        test_random_phase(64'h0000_0000_0100_0000, 64'd0, 64'd0, 64'd42949673, 260);
        test_random_phase({16'd0, any_word()}, {16'd0, scaled_word()},
                          {16'd0, scaled_word()}, {32'd0, $urandom}, 250);
        steady = 1'b1;   // long stretch with no stalls on either side
        test_random_phase(64'hFFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 64'h8000_0000_0000,
                          64'hFFFF_FFFF, 250);
        steady = 1'b0;
        test_random_phase(64'd0, 64'h8000_0000_0000, 64'h7FFF_FFFF_FFFF, 64'd0, 250);
        test_random_phase({16'd0, scaled_word()}, {16'd0, any_word()},
                          {16'd0, any_word()}, {32'd0, $urandom}, 260);
        test_random_phase(64'h0000_0010_0000_0000, 64'd5 << 32, -(64'd7 << 32) & 64'hFFFF_FFFF_FFFF,
                          64'd4294967, 260);

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
